// ===== design/utf8d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared word types, result codes and decoder state for the byte decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CpWidth = 21;

    localparam logic [7:0]         ContMask  = 8'h3F;
    localparam logic [7:0]         Lead2Mask = 8'h1F;
    localparam logic [7:0]         Lead3Mask = 8'h0F;
    localparam logic [7:0]         Lead4Mask = 8'h07;
    localparam logic [7:0]         LeadMin   = 8'hC0;
    localparam logic [7:0]         Lead3Min  = 8'hE0;
    localparam logic [7:0]         Lead4Min  = 8'hF0;
    localparam logic [7:0]         SkipMin   = 8'hF8;
    localparam logic [CpWidth-1:0] BomValue  = 21'h00FEFF;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MISSING_CONT = 2'd0,
        ERR_STRAY_CONT   = 2'd1,
        ERR_BAD_BOM      = 2'd2
    } err_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_flag;
    } src_word_t;

    typedef struct packed {
        kind_t              kind;
        logic [CpWidth-1:0] code_point;
        err_t               error_code;
        logic               text_seen;
    } res_word_t;

    typedef struct packed {
        logic [1:0]         pending_count;
        logic [CpWidth-1:0] accumulator;
        logic               emitted_any;
        logic               halted;
    } dec_state_t;

endpackage

// ===== design/utf8d_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder step logic
// Works out the next decoder state and the optional result for one byte word.
// ----------------------------------------------------------------------------
module utf8d_decode (
    input  utf8d_pkg::src_word_t  word,
    input  utf8d_pkg::dec_state_t state,
    output utf8d_pkg::dec_state_t state_next,
    output logic                  res_fire,
    output utf8d_pkg::res_word_t  res
);
    import utf8d_pkg::*;

    logic [7:0]         b;
    logic [CpWidth-1:0] acc_shift;
    logic [1:0]         pend_dec;

    assign b         = word.in_byte;
    assign acc_shift = {state.accumulator[CpWidth-7:0], b[5:0] & ContMask[5:0]};
    assign pend_dec  = state.pending_count - 2'd1;

    always_comb
    begin
        state_next     = state;
        res_fire       = 1'b0;
        res.kind       = KIND_CHAR;
        res.code_point = '0;
        res.error_code = ERR_MISSING_CONT;
        res.text_seen  = state.emitted_any;

        priority if (word.end_flag)
        begin
            if (!state.halted)
            begin
                res_fire = 1'b1;
                if (state.pending_count != 2'd0)
                begin
                    res.kind = KIND_ERROR;
                end
                else
                begin
                    res.kind = KIND_END;
                end
            end
            state_next = '0;
        end
        else if (state.halted)
        begin
            // Bytes after an error are dropped until the end word.
        end
        else if (b < LeadMin && !b[7])
        begin
            if (state.pending_count != 2'd0)
            begin
                res_fire                 = 1'b1;
                res.kind                 = KIND_ERROR;
                state_next.halted        = 1'b1;
                state_next.pending_count = 2'd0;
            end
            else if (b != 8'h00)
            begin
                res_fire               = 1'b1;
                res.code_point         = {{(CpWidth-8){1'b0}}, b};
                res.text_seen          = 1'b1;
                state_next.emitted_any = 1'b1;
            end
        end
        else if (b < LeadMin)
        begin
            if (state.pending_count == 2'd0)
            begin
                res_fire          = 1'b1;
                res.kind          = KIND_ERROR;
                res.error_code    = ERR_STRAY_CONT;
                state_next.halted = 1'b1;
            end
            else
            begin
                state_next.pending_count = pend_dec;
                state_next.accumulator   = acc_shift;
                if (pend_dec == 2'd0)
                begin
                    if (acc_shift == BomValue)
                    begin
                        // A leading byte order mark is dropped quietly.
                        if (state.emitted_any)
                        begin
                            res_fire          = 1'b1;
                            res.kind          = KIND_ERROR;
                            res.error_code    = ERR_BAD_BOM;
                            state_next.halted = 1'b1;
                        end
                    end
                    else
                    begin
                        res_fire               = 1'b1;
                        res.code_point         = acc_shift;
                        res.text_seen          = 1'b1;
                        state_next.emitted_any = 1'b1;
                    end
                end
            end
        end
        else if (b < Lead3Min)
        begin
            state_next.pending_count = 2'd1;
            state_next.accumulator   = {{(CpWidth-8){1'b0}}, b & Lead2Mask};
        end
        else if (b < Lead4Min)
        begin
            state_next.pending_count = 2'd2;
            state_next.accumulator   = {{(CpWidth-8){1'b0}}, b & Lead3Mask};
        end
        else if (b < SkipMin)
        begin
            state_next.pending_count = 2'd3;
            state_next.accumulator   = {{(CpWidth-8){1'b0}}, b & Lead4Mask};
        end
        else
        begin
            // Bytes from 0xF8 up never occur in the encoding and are skipped.
        end
    end

endmodule

// ===== design/utf8d_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder result register
// Holds one result word for the downstream side and reports when it can load.
// ----------------------------------------------------------------------------
module utf8d_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  utf8d_pkg::res_word_t load_data,
    input  logic                 res_stall,
    output logic                 free,
    output logic                 res_valid,
    output utf8d_pkg::res_word_t res_data
);
    import utf8d_pkg::*;

    logic      valid_reg;
    res_word_t data_reg;

    // The register may take a new word when empty or when its word leaves now.
    assign free      = !valid_reg || !res_stall;
    assign res_valid = valid_reg;
    assign res_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== design/utf8_byte_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder core
// Data path: a byte word is captured in the input register, and its result,
// if any, is loaded from the decode pass into the result register.
// Throughput: one byte word per cycle, set by the single decode pass between
// the input register and the result register; a stalled result holds both.
// Reset: rst_n clears all valid flags and the decoder state asynchronously.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  utf8d_pkg::src_word_t src_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output utf8d_pkg::res_word_t res_data
);
    import utf8d_pkg::*;

    // Input register stage. A word waits here for one decode pass; it moves
    // on whenever the result register can take whatever the pass produces.
    logic       in_valid_reg;
    src_word_t  in_data_reg;

    // Decoder state: pending continuation count, gathered payload bits,
    // whether text has been emitted, and the halted flag after an error.
    dec_state_t state_reg;
    dec_state_t state_next;

    logic       dec_fire;
    res_word_t  dec_res;
    logic       out_free;
    logic       advance;

    // The input stage advances when the result register is free. A word that
    // yields no result also waits for that, which keeps the control simple
    // and still allows one word per cycle while the downstream side flows.
    assign advance   = in_valid_reg && out_free;
    assign src_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (!src_stall)
            begin
                in_valid_reg <= src_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            in_data_reg <= src_data;
        end
    end

    utf8d_decode u_decode (
        .word       (in_data_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res_fire   (dec_fire),
        .res        (dec_res)
    );

    utf8d_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && dec_fire),
        .load_data (dec_res),
        .res_stall (res_stall),
        .free      (out_free),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

endmodule

// ===== test/utf8_byte_stream_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder core testbench
// Feeds directed and random byte streams, each closed by an end-of-stream
// word, into the decoder under several sender and receiver pacing patterns.
// A scoreboard object decodes every accepted word on its own and checks each
// result word against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_core_tb;

    import utf8d_pkg::*;

    localparam int         ClkPeriod   = 20;
    localparam int         ResetCycles = 12;
    localparam int         CycleLimit  = 400000;
    localparam int         DrainCycles = 10;
    localparam int         PhaseWords  = 260;
    localparam int         NumPhases   = 5;
    localparam int         HoldCycles  = 300;
    localparam logic [7:0] ContMin     = 8'h80;
    // The error field reads zero whenever the result is not an error.
    localparam err_t       NoErr       = ERR_MISSING_CONT;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the decoder state plus the queue of
    // result words that the accepted byte words have produced so far.
    // ------------------------------------------------------------------------
    class utf8_scoreboard;
        res_word_t          due_results[$];
        logic [1:0]         cont_due   = '0;
        logic [CpWidth-1:0] partial_cp = '0;
        logic               text_out   = 1'b0;
        logic               locked_out = 1'b0;
        int                 mismatches = 0;
        int                 n_chars    = 0;
        int                 n_errors   = 0;
        int                 n_ends     = 0;

        function void clear_state();
            cont_due   = '0;
            partial_cp = '0;
            text_out   = 1'b0;
            locked_out = 1'b0;
        endfunction

        function void push_result(kind_t k, logic [CpWidth-1:0] cp, err_t e);
            res_word_t r;
            r.kind       = k;
            r.code_point = cp;
            r.error_code = e;
            r.text_seen  = text_out;
            due_results.push_back(r);
        endfunction

        function void flag_error(err_t e);
            locked_out = 1'b1;
            cont_due   = '0;
            push_result(KIND_ERROR, '0, e);
        endfunction

        // Called once for every byte word that the decoder accepts.
        function void decode_word(src_word_t w);
            logic [7:0] b;
            b = w.in_byte;
            if (w.end_flag)
            begin
                if (!locked_out)
                begin
                    if (cont_due != 0)
                        push_result(KIND_ERROR, '0, ERR_MISSING_CONT);
                    else
                        push_result(KIND_END, '0, NoErr);
                end
                clear_state();
            end
            else if (!locked_out)
            begin
                if (b < ContMin)
                begin
                    if (cont_due != 0)
                        flag_error(ERR_MISSING_CONT);
                    else if (b != 8'h00)
                    begin
                        text_out = 1'b1;
                        push_result(KIND_CHAR, {13'd0, b}, NoErr);
                    end
                end
                else if (b < LeadMin)
                begin
                    if (cont_due == 0)
                        flag_error(ERR_STRAY_CONT);
                    else
                    begin
                        cont_due   = cont_due - 2'd1;
                        partial_cp = {partial_cp[CpWidth-7:0], b[5:0]};
                        if (cont_due == 0)
                        begin
                            if (partial_cp == BomValue)
                            begin
                                // A mark before any text is dropped quietly.
                                if (text_out)
                                    flag_error(ERR_BAD_BOM);
                            end
                            else
                            begin
                                text_out = 1'b1;
                                push_result(KIND_CHAR, partial_cp, NoErr);
                            end
                        end
                    end
                end
                else if (b < Lead3Min)
                begin
                    cont_due   = 2'd1;
                    partial_cp = {13'd0, b & Lead2Mask};
                end
                else if (b < Lead4Min)
                begin
                    cont_due   = 2'd2;
                    partial_cp = {13'd0, b & Lead3Mask};
                end
                else if (b < SkipMin)
                begin
                    cont_due   = 2'd3;
                    partial_cp = {13'd0, b & Lead4Mask};
                end
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Called once for every result word that the testbench accepts.
        task check_result(res_word_t got);
            res_word_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result word with nothing expected: %p", got));
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.code_point !== want.code_point)
                report($sformatf("code point %h, expected %h",
                                 got.code_point, want.code_point));
            if (got.error_code !== want.error_code)
                report($sformatf("error code %0d, expected %0d",
                                 got.error_code, want.error_code));
            if (got.text_seen !== want.text_seen)
                report($sformatf("text seen %b, expected %b",
                                 got.text_seen, want.text_seen));
            case (want.kind)
                KIND_CHAR:  n_chars++;
                KIND_ERROR: n_errors++;
                default:    n_ends++;
            endcase
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block.
    // ------------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    src_word_t src_data  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_word_t res_data;

    // Pacing knobs: percent of cycles the sender idles and the receiver stalls.
    int        idle_pct  = 0;
    int        stall_pct = 0;
    logic      hold_off  = 1'b0;
    int        words_sent  = 0;
    int        cycle_count = 0;

    src_word_t stim_q[$];

    utf8_scoreboard sb = new;

    always #(ClkPeriod / 2) clk = ~clk;

    utf8_byte_stream_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // ------------------------------------------------------------------------
    // Receiver: a random stall each cycle, forced high during a hold-off.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: both handshakes are sampled at the same edge, so the order in
    // which the processes wake up cannot change what gets recorded.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
                sb.decode_word(src_data);
            if (res_valid && !res_stall)
                sb.check_result(res_data);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stream builders. Each one appends byte words to the stimulus queue.
    // ------------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        src_word_t w;
        w.in_byte  = b;
        w.end_flag = 1'b0;
        stim_q.push_back(w);
    endfunction

    // The byte field of an end word is ignored, so it carries random bits.
    function automatic void add_end();
        src_word_t w;
        w.in_byte  = 8'($urandom);
        w.end_flag = 1'b1;
        stim_q.push_back(w);
    endfunction

    // Encodes a value in the given number of bytes. Overlong forms and values
    // beyond the Unicode range are produced on purpose.
    function automatic void add_seq(int unsigned nbytes, logic [CpWidth-1:0] cp);
        case (nbytes)
            1:
            begin
                add_byte({1'b0, cp[6:0]});
            end
            2:
            begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // One well-formed character of random length and content. Single-byte
    // characters are kept nonzero, since a null byte emits nothing.
    function automatic void add_char();
        int unsigned        nbytes;
        logic [CpWidth-1:0] cp;
        nbytes = $urandom_range(1, 4);
        cp     = CpWidth'($urandom);
        if (nbytes == 1 && cp[6:0] == 7'd0)
            cp[0] = 1'b1;
        add_seq(nbytes, cp);
    endfunction

    // Something that breaks or perturbs the stream.
    function automatic void add_noise();
        case ($urandom_range(0, 7))
            0: add_byte(8'h00);
            1: add_byte(8'($urandom_range(SkipMin, 8'hFF)));
            2: add_byte(8'($urandom_range(ContMin, LeadMin - 1)));
            3:
            begin
                // A multibyte sequence with its last byte missing.
                add_seq($urandom_range(2, 4), CpWidth'($urandom));
                void'(stim_q.pop_back());
            end
            4:
            begin
                // A lead byte abandoned for whatever comes next.
                add_byte(8'($urandom_range(LeadMin, SkipMin - 1)));
                add_char();
            end
            5: add_seq(3, BomValue);
            6: add_byte(8'($urandom));
            default: add_seq($urandom_range(2, 4), BomValue);
        endcase
    endfunction

    // A complete stream: an optional leading mark, a run of characters with
    // the occasional defect, and the end word.
    function automatic void add_stream();
        int nchars;
        if ($urandom_range(0, 9) == 0)
            add_seq(3, BomValue);
        nchars = $urandom_range(0, 12);
        for (int i = 0; i < nchars; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                add_noise();
            else
                add_char();
        end
        add_end();
    endfunction

    function automatic void add_directed();
        // A leading byte order mark is dropped without a result.
        add_seq(3, BomValue);
        add_byte(8'h41);
        // A null byte with nothing pending is skipped.
        add_byte(8'h00);
        add_byte(8'hC3);
        add_byte(8'hA9);
        // Largest four-byte value, with a skipped 0xFF in the middle of it.
        add_byte(8'hF7);
        add_byte(8'hBF);
        add_byte(8'hFF);
        add_byte(8'hBF);
        add_byte(8'hBF);
        // A two-byte lead cut short by a three-byte lead restarts silently.
        add_byte(8'hC2);
        add_seq(3, 21'h000800);
        // A mark after text is an error; the end word then yields nothing.
        add_seq(3, BomValue);
        add_end();
        // A null byte while a continuation is due, then a byte while halted.
        add_byte(8'hC3);
        add_byte(8'h00);
        add_byte(8'h41);
        add_end();
        // The end word arrives with one continuation byte still due.
        add_byte(8'hE2);
        add_byte(8'h82);
        add_end();
        // A stray continuation, then an empty stream that ends cleanly.
        add_byte(ContMin);
        add_end();
        add_end();
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offers every queued word, idling at random between words. Valid
    // is raised once per word and stays up until the word is taken.
    // ------------------------------------------------------------------------
    task automatic send_all();
        src_word_t w;
        while (stim_q.size() != 0)
        begin
            w = stim_q.pop_front();
            while ($urandom_range(0, 99) < idle_pct)
            begin
                src_valid <= 1'b0;
                @(posedge clk);
            end
            src_valid <= 1'b1;
            src_data  <= w;
            @(posedge clk);
            while (src_stall)
                @(posedge clk);
            words_sent++;
        end
    endtask

    // Long receiver hold-off, counted here so that the sender keeps offering
    // words and the block has to fill up and push back.
    task automatic hold_receiver();
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_directed();
        for (int phase = 0; phase < NumPhases; phase++)
        begin
            // Free running, idle sender, stalling receiver, both, hold-off.
            case (phase)
                1:
                begin
                    idle_pct = 87;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 87;
                end
                3:
                begin
                    idle_pct = 38;
                    stall_pct <= 38;
                end
                default:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
            endcase
            while (stim_q.size() < PhaseWords)
                add_stream();
            if (phase == NumPhases - 1)
            begin
                fork
                    send_all();
                    hold_receiver();
                join
            end
            else
            begin
                send_all();
            end
        end
        src_valid <= 1'b0;

        // Let every expected result come out, then a few more cycles to catch
        // anything extra the block might still produce.
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d byte and end words: directed cases, then random streams",
                 words_sent);
        $display("Checked %0d characters, %0d errors, %0d clean ends; %0d mismatches",
                 sb.n_chars, sb.n_errors, sb.n_ends, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
design/utf8d_pkg.sv
design/utf8d_decode.sv
design/utf8d_out_reg.sv
design/utf8_byte_stream_decoder_core.sv
test/utf8_byte_stream_decoder_core_tb.sv
